FILE: hdl/csdf_pkg.sv
// package for the cable spring-damper force block
// widths, register codes and reset values; no dependencies
`default_nettype none
package csdf_pkg;

    localparam int FRAC_BITS = 16;

    localparam int FLD_W  = 32;
    localparam int CFG_W  = 31;
    localparam int N_IN   = 12;
    localparam int IN_W   = N_IN * FLD_W;
    localparam int OUT_W  = 128;
    localparam int ADDR_W = 4;

    localparam int DW    = FLD_W + 1;
    localparam int SW    = 2 * DW;
    localparam int SQN   = DW;
    localparam int REMW  = DW + 3;
    localparam int DVW   = DW + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam int UW    = FRAC_BITS + 2;
    localparam int PW    = DW + UW;
    localparam int DOTW  = PW + 2;
    localparam int EVW   = DOTW - FRAC_BITS;
    localparam int EHW   = EVW - FRAC_BITS;
    localparam int SPFW  = CFG_W + DW;
    localparam int SPW   = SPFW - FRAC_BITS;
    localparam int DHW   = CFG_W + EHW;
    localparam int DLW   = CFG_W + FRAC_BITS;
    localparam int DMW   = DHW + 1;
    localparam int TW    = ((SPW > DMW) ? SPW : DMW) + 2;
    localparam int FPW   = QW + CFG_W;
    localparam int NST   = 3 + SQN + QW + 6;

    localparam logic [CFG_W-1:0] RST_REST_LENGTH = CFG_W'(65536);
    localparam logic [CFG_W-1:0] RST_SPRING_GAIN = CFG_W'(13107200);
    localparam logic [CFG_W-1:0] RST_DAMPER_GAIN = CFG_W'(655360);
    localparam logic [CFG_W-1:0] RST_FORCE_LIMIT = CFG_W'(3276800);

    typedef enum logic [1:0] {
        REG_REST_LENGTH,
        REG_SPRING_GAIN,
        REG_DAMPER_GAIN,
        REG_FORCE_LIMIT
    } t_reg_idx;

endpackage
`default_nettype wire

FILE: hdl/cable_spring_damper_force_top.sv
// cable spring-damper force top level: apb registers and the full compute pipeline
// depends on csdf_pkg
//
// Tension-only cable force. One request enters per clock while the pipeline
// is not held; the pipeline depth NST is set mostly by the bit-per-stage square
// root (33 stages) and the bit-per-stage direction divider (FRAC_BITS+1 stages).
// The whole pipeline holds while a finished result waits on m_tready.
// Registers are written over the apb port at byte address 4*i; write them
// only while the pipeline is empty.
`default_nettype none
module cable_spring_damper_force_top import csdf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // top_pos_x/y/z, load_pos_x/y/z, top_vel_x/y/z, load_vel_x/y/z
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // force_x, force_y, force_z, tension, zero pad bit
    output logic [OUT_W-1:0]       m_tdata,
    // taut
    output logic                   m_tuser
);

    logic [CFG_W-1:0] r_rest, r_spring, r_damper, r_limit;
    logic [2*CFG_W-1:0] r_rest_sq;
    logic [NST-1:0] r_vld;
    logic en;
    t_reg_idx widx;

    assign widx = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest   <= RST_REST_LENGTH;
            r_spring <= RST_SPRING_GAIN;
            r_damper <= RST_DAMPER_GAIN;
            r_limit  <= RST_FORCE_LIMIT;
        end else if (psel && penable && pwrite) begin
            unique case (widx)
                REG_REST_LENGTH: r_rest   <= pwdata[CFG_W-1:0];
                REG_SPRING_GAIN: r_spring <= pwdata[CFG_W-1:0];
                REG_DAMPER_GAIN: r_damper <= pwdata[CFG_W-1:0];
                REG_FORCE_LIMIT: r_limit  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest_sq <= r_rest * r_rest;
    end

    always_comb begin
        unique case (widx)
            REG_REST_LENGTH: prdata = {1'b0, r_rest};
            REG_SPRING_GAIN: prdata = {1'b0, r_spring};
            REG_DAMPER_GAIN: prdata = {1'b0, r_damper};
            REG_FORCE_LIMIT: prdata = {1'b0, r_limit};
            default:         prdata = '0;
        endcase
    end

    assign en       = !r_vld[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], s_tvalid};
        end
    end

    // stage 0: differences
    logic signed [DW-1:0] r_d0 [3];
    logic signed [DW-1:0] r_v0 [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_d0[i] <= DW'($signed(s_tdata[FLD_W*i +: FLD_W]))
                         - DW'($signed(s_tdata[FLD_W*(3+i) +: FLD_W]));
                r_v0[i] <= DW'($signed(s_tdata[FLD_W*(6+i) +: FLD_W]))
                         - DW'($signed(s_tdata[FLD_W*(9+i) +: FLD_W]));
            end
        end
    end

    // stage 1: squares
    logic [DW-1:0] mag0 [3];
    logic [SW-1:0] r_sq1 [3];
    logic signed [DW-1:0] r_d1 [3];
    logic signed [DW-1:0] r_v1 [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag0[i] = r_d0[i][DW-1] ? DW'(-r_d0[i]) : DW'(r_d0[i]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq1[i] <= mag0[i] * mag0[i];
                r_d1[i]  <= r_d0[i];
                r_v1[i]  <= r_v0[i];
            end
        end
    end

    // stage 2 and square root pipeline
    logic [REMW-1:0]      r_sq_rem  [0:SQN];
    logic [DW-1:0]        r_sq_root [0:SQN];
    logic [SW-1:0]        r_sq_s    [0:SQN];
    logic signed [DW-1:0] r_sq_d    [0:SQN][3];
    logic signed [DW-1:0] r_sq_v    [0:SQN][3];
    logic                 r_sq_taut [0:SQN];
    logic [SW-1:0]        ssum;

    assign ssum = r_sq1[0] + r_sq1[1] + r_sq1[2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_s[0]    <= ssum;
            r_sq_taut[0] <= ssum > SW'(r_rest_sq);
            for (int i = 0; i < 3; i++) begin
                r_sq_d[0][i] <= r_d1[i];
                r_sq_v[0][i] <= r_v1[i];
            end
        end
    end

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        localparam int BI = SQN - 1 - k;
        logic [REMW-1:0] rsh, trial;
        logic ge;
        always_comb begin
            rsh   = {r_sq_rem[k][REMW-3:0], r_sq_s[k][2*BI+1 -: 2]};
            trial = {1'b0, r_sq_root[k], 2'b01};
            ge    = rsh >= trial;
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k+1]  <= ge ? rsh - trial : rsh;
                r_sq_root[k+1] <= {r_sq_root[k][DW-2:0], ge};
                r_sq_s[k+1]    <= r_sq_s[k];
                r_sq_taut[k+1] <= r_sq_taut[k];
                for (int i = 0; i < 3; i++) begin
                    r_sq_d[k+1][i] <= r_sq_d[k][i];
                    r_sq_v[k+1][i] <= r_sq_v[k][i];
                end
            end
        end
    end

    // direction divider pipeline: |d| * 2^F / dist
    logic [DVW-1:0]       r_dv_rem  [0:QW-1][3];
    logic [QW-1:0]        r_dv_q    [0:QW-1][3];
    logic [2:0]           r_dv_neg  [0:QW-1];
    logic [DW-1:0]        r_dv_den  [0:QW-1];
    logic signed [DW-1:0] r_dv_v    [0:QW-1][3];
    logic                 r_dv_taut [0:QW-1];

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [DVW-1:0]       rin  [3];
        logic [QW-1:0]        qin  [3];
        logic [2:0]           nin;
        logic [DW-1:0]        den;
        logic signed [DW-1:0] vin  [3];
        logic                 tin;
        logic [DVW-1:0]       rsh  [3];
        logic [2:0]           ge;
        if (j == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rin[i] = r_sq_d[SQN][i][DW-1] ? DVW'(DW'(-r_sq_d[SQN][i]))
                                                  : DVW'(DW'(r_sq_d[SQN][i]));
                    qin[i] = '0;
                    nin[i] = r_sq_d[SQN][i][DW-1];
                    vin[i] = r_sq_v[SQN][i];
                    rsh[i] = rin[i];
                end
                den = r_sq_root[SQN];
                tin = r_sq_taut[SQN];
            end
        end else begin : g_next
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rin[i] = r_dv_rem[j-1][i];
                    qin[i] = r_dv_q[j-1][i];
                    vin[i] = r_dv_v[j-1][i];
                    rsh[i] = {rin[i][DVW-2:0], 1'b0};
                end
                nin = r_dv_neg[j-1];
                den = r_dv_den[j-1];
                tin = r_dv_taut[j-1];
            end
        end
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                ge[i] = rsh[i] >= {1'b0, den};
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[j][i] <= ge[i] ? rsh[i] - {1'b0, den} : rsh[i];
                    r_dv_q[j][i]   <= {qin[i][QW-2:0], ge[i]};
                    r_dv_v[j][i]   <= vin[i];
                end
                r_dv_neg[j]  <= nin;
                r_dv_den[j]  <= den;
                r_dv_taut[j] <= tin;
            end
        end
    end

    // e1: signed direction, velocity products, spring product
    logic signed [UW-1:0] u1 [3];
    logic signed [UW-1:0] r_u1 [3];
    logic signed [PW-1:0] r_p1 [3];
    logic [SPFW-1:0]      r_spf1;
    logic                 r_t1;
    logic [DW-1:0]        ext;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u1[i] = r_dv_neg[QW-1][i] ? -$signed(UW'(r_dv_q[QW-1][i]))
                                      : $signed(UW'(r_dv_q[QW-1][i]));
        end
        ext = r_dv_den[QW-1] - DW'(r_rest);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_u1[i] <= u1[i];
                r_p1[i] <= r_dv_v[QW-1][i] * u1[i];
            end
            r_spf1 <= r_spring * ext;
            r_t1   <= r_dv_taut[QW-1];
        end
    end

    // e2: dot product, magnitude of along-cable velocity
    logic signed [DOTW-1:0] dot;
    logic [DOTW-1:0]        dabs;
    logic signed [UW-1:0]   r_u2 [3];
    logic [EVW-1:0]         r_ev2;
    logic                   r_n2;
    logic [SPW-1:0]         r_sp2;
    logic                   r_t2;
    always_comb begin
        dot  = DOTW'(r_p1[0]) + DOTW'(r_p1[1]) + DOTW'(r_p1[2]);
        dabs = dot[DOTW-1] ? DOTW'(-dot) : DOTW'(dot);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u2  <= r_u1;
            r_ev2 <= dabs[DOTW-1:FRAC_BITS];
            r_n2  <= dot[DOTW-1];
            r_sp2 <= r_spf1[SPFW-1:FRAC_BITS];
            r_t2  <= r_t1;
        end
    end

    // e3: damper partial products
    logic signed [UW-1:0] r_u3 [3];
    logic [DHW-1:0]       r_dh3;
    logic [DLW-1:0]       r_dl3;
    logic                 r_n3;
    logic [SPW-1:0]       r_sp3;
    logic                 r_t3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u3  <= r_u2;
            r_dh3 <= r_damper * r_ev2[EVW-1:FRAC_BITS];
            r_dl3 <= r_damper * r_ev2[FRAC_BITS-1:0];
            r_n3  <= r_n2;
            r_sp3 <= r_sp2;
            r_t3  <= r_t2;
        end
    end

    // e4: tension and clamp
    logic [DMW-1:0]       dm;
    logic signed [TW-1:0] tsum;
    logic [CFG_W-1:0]     tcl;
    logic signed [UW-1:0] r_u4 [3];
    logic [CFG_W-1:0]     r_ten4;
    logic                 r_t4;
    always_comb begin
        dm   = DMW'(r_dh3) + DMW'(r_dl3[DLW-1:FRAC_BITS]);
        tsum = r_n3 ? $signed(TW'(r_sp3)) - $signed(TW'(dm))
                    : $signed(TW'(r_sp3)) + $signed(TW'(dm));
        priority if (tsum[TW-1]) begin
            tcl = '0;
        end else if (TW'(tsum) > TW'(r_limit)) begin
            tcl = r_limit;
        end else begin
            tcl = tsum[CFG_W-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u4   <= r_u3;
            r_ten4 <= tcl;
            r_t4   <= r_t3;
        end
    end

    // e5: force magnitudes
    logic [QW-1:0]    au [3];
    logic [FPW-1:0]   r_fp5 [3];
    logic [2:0]       r_fn5;
    logic [CFG_W-1:0] r_ten5;
    logic             r_t5;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            au[i] = r_u4[i][UW-1] ? QW'(-r_u4[i]) : QW'(r_u4[i]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_fp5[i] <= au[i] * r_ten4;
                r_fn5[i] <= r_u4[i][UW-1];
            end
            r_ten5 <= r_ten4;
            r_t5   <= r_t4;
        end
    end

    // e6: sign, slack masking, output register
    logic [FLD_W-1:0] fm [3];
    logic [FLD_W-1:0] r_f [3];
    logic [CFG_W-1:0] r_ten;
    logic             r_taut;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fm[i] = r_fp5[i][FPW-1:FRAC_BITS];
            fm[i] = r_fn5[i] ? -fm[i] : fm[i];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_f[i] <= r_t5 ? fm[i] : '0;
            end
            r_ten  <= r_t5 ? r_ten5 : '0;
            r_taut <= r_t5;
        end
    end

    assign m_tdata = {1'b0, r_ten, r_f[2], r_f[1], r_f[0]};
    assign m_tuser = r_taut;

endmodule
`default_nettype wire
